FILE: rtl/core/bmpq_pkg.sv
// Shared types and codes for the bounded max-priority queue.
// No dependencies; imported by the cell and the top level.
package bmpq_pkg;

   // Action field of a request word
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   // Result field widths
   localparam int OUT_VALUE_W = 32;
   localparam int OUT_COUNT_W = 7;

   // What every cell of the chain does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/bmpq_if.sv
// Valid/ready channel interfaces for request and response words.
// Fixed payload widths; no package dependency.
interface bmpq_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface bmpq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] max_value;
   logic               empty_res;
   logic               full_res;
   logic        [6:0]  count;
   logic               rejected;

   modport source (output valid, output max_value, output empty_res, output full_res,
                   output count, output rejected, input ready);
   modport sink   (input valid, input max_value, input empty_res, input full_res,
                   input count, input rejected, output ready);
endinterface

FILE: rtl/core/bmpq_cell.sv
// One slot of the sorted chain (descending: slot 0 holds the maximum).
// Depends on bmpq_pkg for the cell control struct.
module bmpq_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  bmpq_pkg::cell_ctrl_type       ctrl,
   input  logic                          occupied,
   input  logic signed [VALUE_WIDTH-1:0] new_value,
   input  logic                          prev_take,
   input  logic signed [VALUE_WIDTH-1:0] prev_value,
   input  logic signed [VALUE_WIDTH-1:0] next_value,
   output logic                          take,
   output logic signed [VALUE_WIDTH-1:0] value,
   output logic signed [VALUE_WIDTH-1:0] value_in
);
   import bmpq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;

   // New value lands at or above this slot; ties go toward the top
   assign take = !occupied || (new_value >= value_ff);

   // Next slot content
   always_comb begin
      case (ctrl.op)
         CELL_INSERT: begin
            if (take) begin
               value_in = prev_take ? prev_value : new_value;
            end else begin
               value_in = value_ff;
            end
         end
         CELL_DELETE: value_in = next_value;
         default:     value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: rtl/core/bounded_max_priority_queue_unit.sv
// Bounded max-priority queue: a row of CAPACITY cells kept sorted largest-first.
// Every accepted word (insert or delete-max) is applied to all cells together:
// each cell compares the broadcast value with its own slot and shifts one place,
// so the unit takes one word per clock and the response appears in the output
// register in the cycle after acceptance. It stalls only when that register is full
// and not being taken. Rejected words (insert when full, delete when empty) leave
// the contents unchanged. Depends on bmpq_pkg, bmpq_if and bmpq_cell.
module bounded_max_priority_queue_unit #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   bmpq_req_if.sink           req,
   bmpq_rsp_if.source         rsp
);
   import bmpq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic                          accept;
   logic                          reject;
   logic signed [VALUE_WIDTH-1:0] in_value;
   logic signed [VALUE_WIDTH+31:0] in_ext;
   cell_ctrl_type                 ctrl;

   logic [CW-1:0] count_ff, count_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_VALUE_W-1:0] max_ff;
   logic                          empty_ff, full_ff, rej_ff;
   logic [OUT_COUNT_W-1:0]        count_out_ff;

   logic                          take   [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] cell_val    [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] cell_val_in [CAPACITY];

   logic signed [VALUE_WIDTH+31:0] max_ext;
   logic [CW+OUT_COUNT_W-1:0]      count_ext;

   // Handshake: output register frees up when taken
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Sign-extend or trim the request value to the stored width
   assign in_ext   = {{VALUE_WIDTH{req.value[31]}}, req.value};
   assign in_value = in_ext[VALUE_WIDTH-1:0];

   assign reject = (req.action == ACT_INSERT) ? (count_ff == CW'(CAPACITY))
                                              : (count_ff == '0);

   // Chain command
   always_comb begin
      if (!accept || reject) begin
         ctrl.op = CELL_HOLD;
      end else if (req.action == ACT_INSERT) begin
         ctrl.op = CELL_INSERT;
      end else begin
         ctrl.op = CELL_DELETE;
      end
   end

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          p_take;
      logic signed [VALUE_WIDTH-1:0] p_val;
      logic signed [VALUE_WIDTH-1:0] n_val;

      if (i == 0) begin : g_first
         assign p_take = 1'b0;
         assign p_val  = cell_val[i];
      end else begin : g_mid
         assign p_take = take[i-1];
         assign p_val  = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign n_val = cell_val[i];
      end else begin : g_inner
         assign n_val = cell_val[i+1];
      end

      bmpq_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (count_ff > CW'(i)),
         .new_value  (in_value),
         .prev_take  (p_take),
         .prev_value (p_val),
         .next_value (n_val),
         .take       (take[i]),
         .value      (cell_val[i]),
         .value_in   (cell_val_in[i])
      );
   end

   // Occupancy count
   always_comb begin
      case (ctrl.op)
         CELL_INSERT: count_in = count_ff + CW'(1);
         CELL_DELETE: count_in = count_ff - CW'(1);
         default:     count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);
   assign max_ext      = {{32{cell_val_in[0][VALUE_WIDTH-1]}}, cell_val_in[0]};
   assign count_ext    = {{OUT_COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         max_ff       <= (count_in == '0) ? '0 : max_ext[OUT_VALUE_W-1:0];
         empty_ff     <= (count_in == '0);
         full_ff      <= (count_in == CW'(CAPACITY));
         count_out_ff <= count_ext[OUT_COUNT_W-1:0];
         rej_ff       <= reject;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.max_value = max_ff;
   assign rsp.empty_res = empty_ff;
   assign rsp.full_res  = full_ff;
   assign rsp.count     = count_out_ff;
   assign rsp.rejected  = rej_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (cell_val[0] >= cell_val[1]))
      else $error("top two slots out of order");

   a_rej_full: assert property (@(posedge clock) disable iff (reset)
      (accept && req.action == ACT_INSERT && count_ff == CW'(CAPACITY))
      |=> (rsp_valid_ff && rej_ff && $stable(count_ff)))
      else $error("insert into full queue not rejected");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !reject) |=> (count_ff != $past(count_ff)))
      else $error("accepted word did not change occupancy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && empty_ff) |-> (max_ff == '0))
      else $error("empty response with nonzero maximum");

endmodule
